/* design/snell_pkg.sv */
// Shared types and constants for the refraction pipeline.
package snell_pkg;

    localparam logic [14:0] ONE_Q14   = 15'd16384;
    localparam logic [29:0] ONE_Q28   = 30'h1000_0000;
    localparam logic [23:0] SCALE_MAX = 24'hFF_FFFF;
    localparam logic [16:0] KT_RESET  = 17'd65536;
    localparam logic [13:0] IOR_ONE   = 14'd4096;

    // register select (word address bit)
    localparam logic REG_KT  = 1'b0;
    localparam logic REG_IOR = 1'b1;

    typedef struct packed {
        logic [2:0][16:0] n;
        logic [2:0][15:0] w;
        logic [14:0]      c;
        logic [13:0]      p;
        logic [13:0]      q;
        logic [27:0]      psq;
        logic [27:0]      qsq;
        logic             tir;
    } geom_t;

    typedef struct packed {
        logic neg;
        logic sat;
    } lane_flag_t;

    typedef struct packed {
        logic [2:0][16:0] n;
        logic [27:0]      psq;
        logic [27:0]      qsq;
        logic             tir;
        lane_flag_t       flag;
    } lane_t;

    typedef struct packed {
        logic [2:0][15:0] wt;
        logic [2:0][16:0] n;
        logic [27:0]      psq;
        logic [27:0]      qsq;
        logic             tir;
    } post_t;

    typedef struct packed {
        logic [2:0][15:0] wt;
        logic             tir;
        logic             zero;
        logic             sat;
    } fin_t;

endpackage

/* design/snell_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module snell_div_pipe #(
    parameter int DEN_W  = 28,
    parameter int QUO_W  = 29,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  rem_init,
    input  logic [QUO_W-1:0]  num_low,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [QUO_W-1:0]  valid_reg;
    logic [QUO_W-1:0]  valid_in;
    logic [DEN_W-1:0]  rem_reg  [QUO_W];
    logic [DEN_W-1:0]  rem_in   [QUO_W];
    logic [DEN_W-1:0]  rem_next [QUO_W];
    logic [QUO_W-1:0]  lq_reg   [QUO_W];
    logic [QUO_W-1:0]  lq_in    [QUO_W];
    logic [QUO_W-1:0]  lq_next  [QUO_W];
    logic [DEN_W-1:0]  den_reg  [QUO_W];
    logic [DEN_W-1:0]  den_in   [QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];
    logic [SIDE_W-1:0] side_pre [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_link
        if (j == 0) begin : g_first
            assign valid_in[j] = in_valid;
            assign rem_in[j]   = rem_init;
            assign lq_in[j]    = num_low;
            assign den_in[j]   = den;
            assign side_pre[j] = side_in;
        end else begin : g_rest
            assign valid_in[j] = valid_reg[j-1];
            assign rem_in[j]   = rem_reg[j-1];
            assign lq_in[j]    = lq_reg[j-1];
            assign den_in[j]   = den_reg[j-1];
            assign side_pre[j] = side_reg[j-1];
        end
    end

    always_comb
    begin
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;
        for (int j = 0; j < QUO_W; j++)
        begin
            trial       = {rem_in[j], lq_in[j][QUO_W-1]};
            diff        = trial - {1'b0, den_in[j]};
            ge          = trial >= {1'b0, den_in[j]};
            rem_next[j] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            lq_next[j]  = {lq_in[j][QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QUO_W; j++)
        begin
            rem_reg[j]  <= rem_next[j];
            lq_reg[j]   <= lq_next[j];
            den_reg[j]  <= den_in[j];
            side_reg[j] <= side_pre[j];
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = lq_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

/* design/snell_isqrt_pipe.sv */
// Pipelined integer square root, one root bit per stage, with sideband.
module snell_isqrt_pipe #(
    parameter int RES_W  = 15,
    parameter int SIDE_W = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2*RES_W-1:0] radicand,
    input  logic [SIDE_W-1:0]  side_in,
    output logic               out_valid,
    output logic [RES_W-1:0]   root,
    output logic [SIDE_W-1:0]  side_out
);

    logic [RES_W-1:0]   valid_reg;
    logic [RES_W-1:0]   valid_in;
    logic [RES_W+1:0]   rem_reg   [RES_W];
    logic [RES_W+1:0]   rem_in    [RES_W];
    logic [RES_W+1:0]   rem_next  [RES_W];
    logic [RES_W-1:0]   root_reg  [RES_W];
    logic [RES_W-1:0]   root_in   [RES_W];
    logic [RES_W-1:0]   root_next [RES_W];
    logic [2*RES_W-1:0] rad_reg   [RES_W];
    logic [2*RES_W-1:0] rad_in    [RES_W];
    logic [SIDE_W-1:0]  side_reg  [RES_W];
    logic [SIDE_W-1:0]  side_pre  [RES_W];

    for (genvar j = 0; j < RES_W; j++) begin : g_link
        if (j == 0) begin : g_first
            assign valid_in[j] = in_valid;
            assign rem_in[j]   = '0;
            assign root_in[j]  = '0;
            assign rad_in[j]   = radicand;
            assign side_pre[j] = side_in;
        end else begin : g_rest
            assign valid_in[j] = valid_reg[j-1];
            assign rem_in[j]   = rem_reg[j-1];
            assign root_in[j]  = root_reg[j-1];
            assign rad_in[j]   = rad_reg[j-1];
            assign side_pre[j] = side_reg[j-1];
        end
    end

    always_comb
    begin
        logic [RES_W+3:0] rem_t;
        logic [RES_W+3:0] trial;
        logic [RES_W+3:0] diff;
        logic             ge;
        for (int j = 0; j < RES_W; j++)
        begin
            rem_t        = {rem_in[j], rad_in[j][2*RES_W-1 -: 2]};
            trial        = {2'b00, root_in[j], 2'b01};
            diff         = rem_t - trial;
            ge           = rem_t >= trial;
            rem_next[j]  = ge ? diff[RES_W+1:0] : rem_t[RES_W+1:0];
            root_next[j] = {root_in[j][RES_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < RES_W; j++)
        begin
            rem_reg[j]  <= rem_next[j];
            root_reg[j] <= root_next[j];
            rad_reg[j]  <= {rad_in[j][2*RES_W-3:0], 2'b00};
            side_reg[j] <= side_pre[j];
        end
    end

    assign out_valid = valid_reg[RES_W-1];
    assign root      = root_reg[RES_W-1];
    assign side_out  = side_reg[RES_W-1];

endmodule

/* design/snell_refraction_unit_top.sv */
// Refraction unit top: Snell direction, total reflection flag and radiance scale.
//
// channel  | ports                                        | transfer
// ---------+----------------------------------------------+-------------------------
// config   | psel penable pwrite paddr pwdata prdata      | psel&penable&pwrite&pready
// input    | normal_x/y/z out_dir_x/y/z                   | start & !busy
// result   | trans_dir_x/y/z radiance_scale total_internal| done (one cycle)
//
// One ray per cycle; busy is never raised. The path runs through the
// four bit-serial pipelines: t divide (29), square root (15), direction
// divide (15), scale divide (24), plus 14 arithmetic stages.
// Reset clears the valid bits and loads kt = 1.0, ior = 1.0.
// Results cannot be stalled by the receiver.
module snell_refraction_unit_top
    import snell_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic signed [15:0] out_dir_x,
    input  logic signed [15:0] out_dir_y,
    input  logic signed [15:0] out_dir_z,
    output logic               done,
    output logic signed [15:0] trans_dir_x,
    output logic signed [15:0] trans_dir_y,
    output logic signed [15:0] trans_dir_z,
    output logic [23:0]        radiance_scale,
    output logic               total_internal
);

    localparam int T_QUO_W  = 29;
    localparam int SQ_RES_W = 15;
    localparam int L_QUO_W  = 15;
    localparam int S_QUO_W  = 24;
    localparam int LATENCY  = 5 + T_QUO_W + SQ_RES_W + 4 + L_QUO_W + 4 + S_QUO_W + 1;

    logic [16:0] kt_reg;
    logic [13:0] ior_reg;
    logic        accept;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kt_reg  <= KT_RESET;
            ior_reg <= IOR_ONE;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_KT:  kt_reg  <= pwdata[16:0];
                REG_IOR: ior_reg <= pwdata[13:0];
                default: kt_reg  <= kt_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_KT:  prdata = {15'd0, kt_reg};
            REG_IOR: prdata = {18'd0, ior_reg};
            default: prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // stage 1: products n*wo
    logic               s1_valid_reg;
    logic signed [15:0] s1_n_reg    [3];
    logic signed [15:0] s1_w_reg    [3];
    logic signed [31:0] s1_prod_reg [3];
    logic signed [15:0] in_n [3];
    logic signed [15:0] in_w [3];

    assign in_n[0] = normal_x;
    assign in_n[1] = normal_y;
    assign in_n[2] = normal_z;
    assign in_w[0] = out_dir_x;
    assign in_w[1] = out_dir_y;
    assign in_w[2] = out_dir_z;

    // stage 2: cos, flip, eta ratio
    logic               s2_valid_reg;
    geom_t              s2_geom_reg;
    geom_t              s2_geom_next;
    logic signed [33:0] dot_next;
    logic               flip_next;
    logic [32:0]        mag_next;
    logic [19:0]        c_round_next;
    logic [13:0]        r_next;
    logic signed [16:0] n17_next [3];

    always_comb
    begin
        dot_next     = 34'(s1_prod_reg[0]) + 34'(s1_prod_reg[1]) + 34'(s1_prod_reg[2]);
        flip_next    = dot_next[33];
        mag_next     = flip_next ? 33'(-dot_next) : 33'(dot_next);
        c_round_next = 20'((34'(mag_next) + 34'd8192) >> 14);
        r_next       = (ior_reg == '0) ? 14'd1 : ior_reg;
        s2_geom_next = '0;
        s2_geom_next.c = (c_round_next > 20'(ONE_Q14)) ? ONE_Q14 : c_round_next[14:0];
        s2_geom_next.p = flip_next ? r_next : IOR_ONE;
        s2_geom_next.q = flip_next ? IOR_ONE : r_next;
        for (int i = 0; i < 3; i++)
        begin
            n17_next[i]       = 17'(s1_n_reg[i]);
            s2_geom_next.n[i] = flip_next ? -n17_next[i] : n17_next[i];
            s2_geom_next.w[i] = s1_w_reg[i];
        end
    end

    // stage 3: squares
    logic        s3_valid_reg;
    geom_t       s3_geom_reg;
    geom_t       s3_geom_next;
    logic [29:0] s3_csq_reg;

    always_comb
    begin
        s3_geom_next     = s2_geom_reg;
        s3_geom_next.psq = 28'(28'(s2_geom_reg.p) * 28'(s2_geom_reg.p));
        s3_geom_next.qsq = 28'(28'(s2_geom_reg.q) * 28'(s2_geom_reg.q));
    end

    // stage 4: (1 - c^2) p^2 against q^2
    logic        s4_valid_reg;
    geom_t       s4_geom_reg;
    logic [56:0] s4_lhs_reg;
    logic [56:0] s4_rhs_reg;
    logic [29:0] x_next;

    assign x_next = ONE_Q28 - s3_csq_reg;

    // stage 5: reflection test, numerator of t
    logic        s5_valid_reg;
    geom_t       s5_geom_reg;
    geom_t       s5_geom_next;
    logic [56:0] s5_num_reg;

    always_comb
    begin
        s5_geom_next     = s4_geom_reg;
        s5_geom_next.tir = s4_lhs_reg > s4_rhs_reg;
    end

    // t = num / q^2
    logic        t_valid;
    logic [28:0] t_quo;
    geom_t       t_geom;

    snell_div_pipe #(
        .DEN_W  (28),
        .QUO_W  (T_QUO_W),
        .SIDE_W ($bits(geom_t))
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .rem_init  (s5_num_reg[56:29]),
        .num_low   (s5_num_reg[28:0]),
        .den       (s5_geom_reg.qsq),
        .side_in   (s5_geom_reg),
        .out_valid (t_valid),
        .quo       (t_quo),
        .side_out  (t_geom)
    );

    // cos2 = sqrt(t)
    logic        sq_valid;
    logic [14:0] sq_root;
    geom_t       sq_geom;

    snell_isqrt_pipe #(
        .RES_W  (SQ_RES_W),
        .SIDE_W ($bits(geom_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (t_valid),
        .radicand  ({1'b0, t_quo}),
        .side_in   (t_geom),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_geom)
    );

    // stage 6..9: k, numerators, rounding bias
    logic               s6_valid_reg;
    geom_t              s6_geom_reg;
    logic [28:0]        s6_cq_reg;
    logic [28:0]        s6_cp_reg;
    logic               s7_valid_reg;
    geom_t              s7_geom_reg;
    logic signed [29:0] s7_k_reg;
    logic signed [29:0] k_next;
    logic               s8_valid_reg;
    geom_t              s8_geom_reg;
    logic signed [30:0] s8_wp_reg [3];
    logic signed [46:0] s8_nk_reg [3];
    logic               s9_valid_reg;
    geom_t              s9_geom_reg;
    logic [47:0]        s9_mp_reg  [3];
    logic               s9_neg_reg [3];
    logic signed [47:0] num_next   [3];
    logic [47:0]        mag48_next [3];

    assign k_next = $signed({1'b0, s6_cq_reg}) - $signed({1'b0, s6_cp_reg});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_next[i]   = -(48'(s8_wp_reg[i]) <<< 14) - 48'(s8_nk_reg[i]);
            mag48_next[i] = num_next[i][47] ? 48'(-num_next[i]) : 48'(num_next[i]);
        end
    end

    // direction lanes: round(num / (q << 14))
    logic        lane_sat  [3];
    logic [13:0] lane_rem  [3];
    lane_t       lane_x_side;
    lane_flag_t  lane_y_side;
    lane_flag_t  lane_z_side;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lane_sat[i] = s9_mp_reg[i][47:29] >= 19'(s9_geom_reg.q);
            lane_rem[i] = lane_sat[i] ? 14'd0 : s9_mp_reg[i][42:29];
        end
        lane_x_side.n        = s9_geom_reg.n;
        lane_x_side.psq      = s9_geom_reg.psq;
        lane_x_side.qsq      = s9_geom_reg.qsq;
        lane_x_side.tir      = s9_geom_reg.tir;
        lane_x_side.flag.neg = s9_neg_reg[0];
        lane_x_side.flag.sat = lane_sat[0];
        lane_y_side.neg      = s9_neg_reg[1];
        lane_y_side.sat      = lane_sat[1];
        lane_z_side.neg      = s9_neg_reg[2];
        lane_z_side.sat      = lane_sat[2];
    end

    logic        lx_valid;
    logic        ly_valid;
    logic        lz_valid;
    logic [14:0] lx_quo;
    logic [14:0] ly_quo;
    logic [14:0] lz_quo;
    lane_t       lx_side;
    lane_flag_t  ly_flag;
    lane_flag_t  lz_flag;

    snell_div_pipe #(
        .DEN_W  (14),
        .QUO_W  (L_QUO_W),
        .SIDE_W ($bits(lane_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s9_valid_reg),
        .rem_init  (lane_rem[0]),
        .num_low   (s9_mp_reg[0][28:14]),
        .den       (s9_geom_reg.q),
        .side_in   (lane_x_side),
        .out_valid (lx_valid),
        .quo       (lx_quo),
        .side_out  (lx_side)
    );

    snell_div_pipe #(
        .DEN_W  (14),
        .QUO_W  (L_QUO_W),
        .SIDE_W ($bits(lane_flag_t))
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s9_valid_reg),
        .rem_init  (lane_rem[1]),
        .num_low   (s9_mp_reg[1][28:14]),
        .den       (s9_geom_reg.q),
        .side_in   (lane_y_side),
        .out_valid (ly_valid),
        .quo       (ly_quo),
        .side_out  (ly_flag)
    );

    snell_div_pipe #(
        .DEN_W  (14),
        .QUO_W  (L_QUO_W),
        .SIDE_W ($bits(lane_flag_t))
    ) u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s9_valid_reg),
        .rem_init  (lane_rem[2]),
        .num_low   (s9_mp_reg[2][28:14]),
        .den       (s9_geom_reg.q),
        .side_in   (lane_z_side),
        .out_valid (lz_valid),
        .quo       (lz_quo),
        .side_out  (lz_flag)
    );

    // stage 10: saturate and sign wt
    logic        s10_valid_reg;
    post_t       s10_post_reg;
    post_t       s10_post_next;
    logic [14:0] lane_quo  [3];
    lane_flag_t  lane_flag [3];
    logic [14:0] wt_mag    [3];

    assign lane_quo[0]  = lx_quo;
    assign lane_quo[1]  = ly_quo;
    assign lane_quo[2]  = lz_quo;
    assign lane_flag[0] = lx_side.flag;
    assign lane_flag[1] = ly_flag;
    assign lane_flag[2] = lz_flag;

    always_comb
    begin
        s10_post_next.n   = lx_side.n;
        s10_post_next.psq = lx_side.psq;
        s10_post_next.qsq = lx_side.qsq;
        s10_post_next.tir = lx_side.tir;
        for (int i = 0; i < 3; i++)
        begin
            wt_mag[i] = (lane_flag[i].sat || lane_quo[i] > ONE_Q14) ? ONE_Q14 : lane_quo[i];
            s10_post_next.wt[i] = lane_flag[i].neg ? -16'(wt_mag[i]) : 16'(wt_mag[i]);
        end
    end

    // stage 11..13: n.wt, kt p^2, q^2 |n.wt|
    logic               s11_valid_reg;
    post_t              s11_post_reg;
    logic signed [32:0] s11_nwt_reg [3];
    logic               s12_valid_reg;
    post_t              s12_post_reg;
    logic [31:0]        s12_ad_reg;
    logic [44:0]        s12_a_reg;
    logic signed [34:0] d_next;
    logic               s13_valid_reg;
    post_t              s13_post_reg;
    logic [59:0]        s13_den_reg;
    logic [44:0]        s13_a_reg;

    assign d_next = 35'(s11_nwt_reg[0]) + 35'(s11_nwt_reg[1]) + 35'(s11_nwt_reg[2]);

    // scale = a * 2^28 / den
    fin_t        sc_side;
    logic [59:0] sc_a16;
    logic [59:0] sc_rem;

    always_comb
    begin
        sc_a16       = 60'({s13_a_reg, 4'd0});
        sc_side.wt   = s13_post_reg.wt;
        sc_side.tir  = s13_post_reg.tir;
        sc_side.zero = s13_a_reg == '0;
        sc_side.sat  = (s13_den_reg == '0) || (sc_a16 >= s13_den_reg);
        sc_rem       = (sc_side.zero || sc_side.sat) ? 60'd0 : sc_a16;
    end

    logic        sc_valid;
    logic [23:0] sc_quo;
    fin_t        sc_fin;

    snell_div_pipe #(
        .DEN_W  (60),
        .QUO_W  (S_QUO_W),
        .SIDE_W ($bits(fin_t))
    ) u_div_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s13_valid_reg),
        .rem_init  (sc_rem),
        .num_low   (24'd0),
        .den       (s13_den_reg),
        .side_in   (sc_side),
        .out_valid (sc_valid),
        .quo       (sc_quo),
        .side_out  (sc_fin)
    );

    // output register
    logic               done_reg;
    logic signed [15:0] dir_reg [3];
    logic [23:0]        scale_reg;
    logic               tir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= sq_valid;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= lx_valid && ly_valid && lz_valid;
            s11_valid_reg <= s10_valid_reg;
            s12_valid_reg <= s11_valid_reg;
            s13_valid_reg <= s12_valid_reg;
            done_reg      <= sc_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            s1_n_reg[i]    <= in_n[i];
            s1_w_reg[i]    <= in_w[i];
            s1_prod_reg[i] <= 32'(in_n[i]) * 32'(in_w[i]);
        end

        s2_geom_reg <= s2_geom_next;

        s3_geom_reg <= s3_geom_next;
        s3_csq_reg  <= 30'(s2_geom_reg.c) * 30'(s2_geom_reg.c);

        s4_geom_reg <= s3_geom_reg;
        s4_lhs_reg  <= 57'(x_next) * 57'(s3_geom_reg.psq);
        s4_rhs_reg  <= {1'b0, s3_geom_reg.qsq, 28'd0};

        s5_geom_reg <= s5_geom_next;
        s5_num_reg  <= s4_rhs_reg - s4_lhs_reg;

        s6_geom_reg <= sq_geom;
        s6_cq_reg   <= 29'(29'(sq_root) * 29'(sq_geom.q));
        s6_cp_reg   <= 29'(29'(sq_geom.c) * 29'(sq_geom.p));

        s7_geom_reg <= s6_geom_reg;
        s7_k_reg    <= k_next;

        s8_geom_reg <= s7_geom_reg;
        for (int i = 0; i < 3; i++)
        begin
            s8_wp_reg[i] <= 31'($signed(s7_geom_reg.w[i])) * 31'($signed({1'b0, s7_geom_reg.p}));
            s8_nk_reg[i] <= 47'($signed(s7_geom_reg.n[i])) * 47'(s7_k_reg);
        end

        s9_geom_reg <= s8_geom_reg;
        for (int i = 0; i < 3; i++)
        begin
            s9_neg_reg[i] <= num_next[i][47];
            s9_mp_reg[i]  <= mag48_next[i] + 48'({s8_geom_reg.q, 13'd0});
        end

        s10_post_reg <= s10_post_next;

        s11_post_reg <= s10_post_reg;
        for (int i = 0; i < 3; i++)
        begin
            s11_nwt_reg[i] <= 33'($signed(s10_post_reg.n[i]))
                              * 33'($signed(s10_post_reg.wt[i]));
        end

        s12_post_reg <= s11_post_reg;
        s12_ad_reg   <= d_next[34] ? 32'(-d_next) : 32'(d_next);
        s12_a_reg    <= 45'(kt_reg) * 45'(s11_post_reg.psq);

        s13_post_reg <= s12_post_reg;
        s13_den_reg  <= 60'(s12_post_reg.qsq) * 60'(s12_ad_reg);
        s13_a_reg    <= s12_a_reg;

        tir_reg <= sc_fin.tir;
        for (int i = 0; i < 3; i++)
        begin
            dir_reg[i] <= sc_fin.tir ? 16'sd0 : $signed(sc_fin.wt[i]);
        end
        if (sc_fin.tir || sc_fin.zero)
        begin
            scale_reg <= '0;
        end
        else if (sc_fin.sat)
        begin
            scale_reg <= SCALE_MAX;
        end
        else
        begin
            scale_reg <= sc_quo;
        end
    end

    assign done           = done_reg;
    assign trans_dir_x    = dir_reg[0];
    assign trans_dir_y    = dir_reg[1];
    assign trans_dir_z    = dir_reg[2];
    assign radiance_scale = scale_reg;
    assign total_internal = tir_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transfer did not produce a result at the expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching input transfer");

    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && total_internal) |-> (trans_dir_x == 16'sd0 && trans_dir_y == 16'sd0
                                      && trans_dir_z == 16'sd0 && radiance_scale == 24'd0))
        else $error("total reflection result not zeroed");

    a_dir_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !total_internal) |->
            (trans_dir_x >= -16'sd16384 && trans_dir_x <= 16'sd16384
             && trans_dir_y >= -16'sd16384 && trans_dir_y <= 16'sd16384
             && trans_dir_z >= -16'sd16384 && trans_dir_z <= 16'sd16384))
        else $error("direction component out of range");

endmodule
